// ----- hdl/qkvls_pkg.sv -----
`timescale 1ns / 1ps

package qkvls_pkg;

  // key store: three 64-bit registers of eight characters each
  localparam int MAX_KEY_LENGTH = 24;
  localparam int KEY_POS_W      = $clog2(MAX_KEY_LENGTH + 1);
  localparam int REG_DATA_W     = 64;
  localparam int ADDR_W         = 6;
  localparam int REG_SEL_W      = 3;

  // characters the scanner reacts to
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

  // register indexes, at byte address 8 * index
  localparam logic [REG_SEL_W-1:0] REG_KEY_CHARS_A    = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_KEY_CHARS_B    = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_KEY_CHARS_C    = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_KEY_LENGTH     = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_VALUE_CAPACITY = 3'd4;

  localparam logic [KEY_POS_W-1:0] KEY_LENGTH_RESET     = 5'd1;
  localparam logic [7:0]           VALUE_CAPACITY_RESET = 8'd16;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_UNTERM   = 2'd1,
    ST_LONG     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [MAX_KEY_LENGTH-1:0][7:0] key_chars;
    logic [KEY_POS_W-1:0]           key_length;
    logic [7:0]                     value_capacity;
  } cfg_t;

endpackage

// ----- hdl/qkvls_cfg.sv -----
`timescale 1ns / 1ps

module qkvls_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qkvls_pkg::ADDR_W-1:0]   paddr,
  input  logic [qkvls_pkg::REG_DATA_W-1:0] pwdata,
  output logic [qkvls_pkg::REG_DATA_W-1:0] prdata,
  output logic                           pready,
  output qkvls_pkg::cfg_t                cfg
);
  import qkvls_pkg::*;

  logic [REG_DATA_W-1:0] key_chars_a;
  logic [REG_DATA_W-1:0] key_chars_b;
  logic [REG_DATA_W-1:0] key_chars_c;
  logic [KEY_POS_W-1:0]  key_length;
  logic [7:0]            value_capacity;
  logic [REG_SEL_W-1:0]  reg_sel;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:ADDR_W-REG_SEL_W];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars_a    <= '0;
      key_chars_b    <= '0;
      key_chars_c    <= '0;
      key_length     <= KEY_LENGTH_RESET;
      value_capacity <= VALUE_CAPACITY_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KEY_CHARS_A:    key_chars_a    <= pwdata;
        REG_KEY_CHARS_B:    key_chars_b    <= pwdata;
        REG_KEY_CHARS_C:    key_chars_c    <= pwdata;
        REG_KEY_LENGTH:     key_length     <= pwdata[KEY_POS_W-1:0];
        REG_VALUE_CAPACITY: value_capacity <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_KEY_CHARS_A:    prdata = key_chars_a;
      REG_KEY_CHARS_B:    prdata = key_chars_b;
      REG_KEY_CHARS_C:    prdata = key_chars_c;
      REG_KEY_LENGTH:     prdata = {{(REG_DATA_W-KEY_POS_W){1'b0}}, key_length};
      REG_VALUE_CAPACITY: prdata = {{(REG_DATA_W-8){1'b0}}, value_capacity};
      default:            prdata = '0;
    endcase
  end

  assign cfg.key_chars      = {key_chars_c, key_chars_b, key_chars_a};
  assign cfg.key_length     = key_length;
  assign cfg.value_capacity = value_capacity;

endmodule

// ----- hdl/quoted_key_value_line_scanner.sv -----
`timescale 1ns / 1ps

// channel  | handshake                       | payload
// ---------+---------------------------------+------------------------------------
// text     | text_valid / text_ready         | text_byte, end_of_buffer
// result   | result_valid / result_ready     | is_status, value_char, status_code
// config   | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
// one text byte per cycle while no held result stalls the input; a byte reaches the result register
// after acceptance through the input register, then the per-byte phase update into the result register
// rst is synchronous and active high; it clears the scan state, the valid flags and the config registers
// a held result stalls the input register, which in turn drops text_ready

module quoted_key_value_line_scanner (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             text_valid,
  output logic                             text_ready,
  input  logic [7:0]                       text_byte,
  input  logic                             end_of_buffer,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic                             is_status,
  output logic [7:0]                       value_char,
  output logic [1:0]                       status_code,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qkvls_pkg::ADDR_W-1:0]     paddr,
  input  logic [qkvls_pkg::REG_DATA_W-1:0] pwdata,
  output logic [qkvls_pkg::REG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import qkvls_pkg::*;

  typedef enum logic [2:0] {
    PH_KEY   = 3'd0,
    PH_QUOTE = 3'd1,
    PH_VALUE = 3'd2,
    PH_SKIP  = 3'd3,
    PH_DRAIN = 3'd4
  } phase_t;

  cfg_t cfg;

  // input register
  logic       stage_valid;
  logic [7:0] text_q;
  logic       eob_q;

  // scan state
  phase_t               scan_phase, scan_phase_next;
  logic [KEY_POS_W-1:0] key_position, key_position_next;
  logic [7:0]           value_count, value_count_next;

  logic                 proc_go;
  logic                 emit;
  logic                 emit_status;
  status_t              emit_code;
  logic                 finish;
  status_t              finish_code;
  logic [KEY_POS_W-1:0] key_len;
  logic [7:0]           key_byte;
  logic [8:0]           count_inc;

  qkvls_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign proc_go    = stage_valid & (~result_valid | result_ready);
  assign text_ready = ~stage_valid | proc_go;

  // effective key length and current key character
  assign key_len  = (cfg.key_length > KEY_POS_W'(MAX_KEY_LENGTH)) ?
                    KEY_POS_W'(MAX_KEY_LENGTH) : cfg.key_length;
  assign key_byte = (key_position < KEY_POS_W'(MAX_KEY_LENGTH)) ?
                    cfg.key_chars[key_position] : CHAR_NUL;
  assign count_inc = {1'b0, value_count} + 9'd1;

  // per-byte phase update
  always_comb begin
    scan_phase_next   = scan_phase;
    key_position_next = key_position;
    value_count_next  = value_count;
    finish            = 1'b0;
    finish_code       = ST_NOTFOUND;
    emit              = 1'b0;
    emit_status       = 1'b0;
    emit_code         = ST_FOUND;

    unique case (scan_phase)
      PH_KEY: begin
        if (text_q == CHAR_NUL) begin
          finish = 1'b1;
        end else begin
          if (text_q == CHAR_NEWLINE) begin
            key_position_next = '0;
          end else if (key_position < key_len) begin
            if (text_q == key_byte) key_position_next = key_position + KEY_POS_W'(1);
            else scan_phase_next = PH_SKIP;
          end else if (text_q == CHAR_EQUALS) begin
            scan_phase_next = PH_QUOTE;
          end else begin
            scan_phase_next = PH_SKIP;
          end
          finish = eob_q;
        end
      end
      PH_QUOTE: begin
        if (text_q == CHAR_NUL) begin
          finish = 1'b1;
        end else if (text_q == CHAR_NEWLINE) begin
          scan_phase_next   = PH_KEY;
          key_position_next = '0;
          finish            = eob_q;
        end else if (text_q == CHAR_QUOTE) begin
          if (cfg.value_capacity == 8'd0) begin
            finish      = 1'b1;
            finish_code = ST_LONG;
          end else begin
            scan_phase_next  = PH_VALUE;
            value_count_next = '0;
            finish           = eob_q;
            finish_code      = ST_UNTERM;
          end
        end else begin
          scan_phase_next = PH_SKIP;
          finish          = eob_q;
        end
      end
      PH_VALUE: begin
        priority if (text_q == CHAR_QUOTE) begin
          finish      = 1'b1;
          finish_code = ST_FOUND;
        end else if (text_q == CHAR_NUL) begin
          finish      = 1'b1;
          finish_code = ST_UNTERM;
        end else if (count_inc >= {1'b0, cfg.value_capacity}) begin
          finish      = 1'b1;
          finish_code = ST_LONG;
        end else if (eob_q) begin
          finish      = 1'b1;
          finish_code = ST_UNTERM;
        end else begin
          value_count_next = count_inc[7:0];
          emit             = 1'b1;
        end
      end
      PH_SKIP: begin
        if (text_q == CHAR_NUL) begin
          finish = 1'b1;
        end else begin
          if (text_q == CHAR_NEWLINE) begin
            scan_phase_next   = PH_KEY;
            key_position_next = '0;
          end
          finish = eob_q;
        end
      end
      default: begin
        // draining to the end of the buffer after the status
        if (eob_q) begin
          scan_phase_next   = PH_KEY;
          key_position_next = '0;
          value_count_next  = '0;
        end
      end
    endcase

    // final status ends the search
    if (finish) begin
      emit              = 1'b1;
      emit_status       = 1'b1;
      emit_code         = finish_code;
      scan_phase_next   = eob_q ? PH_KEY : PH_DRAIN;
      key_position_next = '0;
      value_count_next  = '0;
    end
  end

  // input register, scan state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      scan_phase   <= PH_KEY;
      key_position <= '0;
      value_count  <= '0;
    end else begin
      if (text_ready) stage_valid <= text_valid;
      if (proc_go) begin
        result_valid <= emit;
        scan_phase   <= scan_phase_next;
        key_position <= key_position_next;
        value_count  <= value_count_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (text_valid && text_ready) begin
      text_q <= text_byte;
      eob_q  <= end_of_buffer;
    end
    if (proc_go && emit) begin
      is_status   <= emit_status;
      value_char  <= emit_status ? CHAR_NUL : text_q;
      status_code <= emit_status ? emit_code : ST_FOUND;
    end
  end

`ifndef NO_ASSERTIONS
  // key match never runs past the key store
  a_key_pos_bound: assert property (@(posedge clk) disable iff (rst)
    key_position <= KEY_POS_W'(MAX_KEY_LENGTH))
    else $error("key position beyond key store");

  // a value byte is never a terminator and carries no status
  a_value_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_status) |->
      (value_char != CHAR_NUL && value_char != CHAR_QUOTE && status_code == ST_FOUND))
    else $error("bad value byte result");

  // a byte held in the input register waits unchanged
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !proc_go) |=> (stage_valid && $stable(text_q) && $stable(eob_q)))
    else $error("input register lost a waiting byte");

  // a status result restarts the counters
  a_status_clears: assert property (@(posedge clk) disable iff (rst)
    (proc_go && emit_status) |=>
      (result_valid && is_status && key_position == '0 && value_count == '0))
    else $error("status did not clear scan counters");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import qkvls_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_COUNT    = 9;
  localparam int PHASE_BYTES    = 90;
  localparam int REPORT_LIMIT   = 10;

  // scan position inside the buffer
  typedef enum logic [2:0] {
    SCAN_KEY,
    SCAN_QUOTE,
    SCAN_VALUE,
    SCAN_SKIP,
    SCAN_DRAIN
  } scan_state_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] value_char;
    status_t    status_code;
  } scan_result_t;

  // one directed step: a text byte, or a register write when is_cfg is set
  typedef struct {
    logic [7:0]            text;
    logic                  eob;
    bit                    pinned;
    status_t               pin_code;
    bit                    is_cfg;
    logic [REG_SEL_W-1:0]  reg_sel;
    logic [REG_DATA_W-1:0] reg_value;
  } stim_row_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  text_valid    = 1'b0;
  logic                  text_ready;
  logic [7:0]            text_byte     = 8'h00;
  logic                  end_of_buffer = 1'b0;
  logic                  result_valid;
  logic                  result_ready  = 1'b0;
  logic                  is_status;
  logic [7:0]            value_char;
  logic [1:0]            status_code;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [ADDR_W-1:0]     paddr         = '0;
  logic [REG_DATA_W-1:0] pwdata        = '0;
  logic [REG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the scanner: registers and scan state
  logic [7:0]           key_store [MAX_KEY_LENGTH];
  logic [KEY_POS_W-1:0] key_len_q   = KEY_LENGTH_RESET;
  logic [7:0]           cap_q       = VALUE_CAPACITY_RESET;
  scan_state_t          scan_state  = SCAN_KEY;
  int                   key_pos     = 0;
  int                   value_len   = 0;
  scan_result_t         step_result;

  scan_result_t pending_results [$];
  logic [7:0]   buffer_bytes [$];
  int           error_count   = 0;
  int           idle_cycles   = 0;
  int           send_idle_pct = 35;
  int           recv_idle_pct = 53;

  stim_row_t directed_rows [32] = '{
    // reset key is a single NUL, so this is a stray NUL ending the search
    '{CHAR_NUL,     1, 1, ST_NOTFOUND, 0, REG_KEY_CHARS_A,    0},
    // key "K", widest value store
    '{8'h00,        0, 0, ST_FOUND,    1, REG_KEY_CHARS_A,    64'h4B},
    '{8'h00,        0, 0, ST_FOUND,    1, REG_VALUE_CAPACITY, 255},
    // newline restarts the key, then a short quoted value
    '{CHAR_NEWLINE, 0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{"K",          0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_EQUALS,  0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_QUOTE,   0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{"a",          0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_QUOTE,   1, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    // buffer ends on the equals sign
    '{"K",          0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_EQUALS,  1, 1, ST_NOTFOUND, 0, REG_KEY_CHARS_A,    0},
    // buffer ends on the opening quote
    '{"K",          0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_EQUALS,  0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_QUOTE,   1, 1, ST_UNTERM,   0, REG_KEY_CHARS_A,    0},
    // value cut short by the buffer end
    '{"K",          0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_EQUALS,  0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_QUOTE,   0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{"a",          1, 1, ST_UNTERM,   0, REG_KEY_CHARS_A,    0},
    // NUL inside the value, then the rest of the buffer is drained
    '{"K",          0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_EQUALS,  0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_QUOTE,   0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_NUL,     0, 1, ST_UNTERM,   0, REG_KEY_CHARS_A,    0},
    '{8'hFF,        1, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    // store of one: the first value character is already too long
    '{8'h00,        0, 0, ST_FOUND,    1, REG_VALUE_CAPACITY, 1},
    '{"K",          0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_EQUALS,  0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_QUOTE,   0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{"a",          1, 1, ST_LONG,     0, REG_KEY_CHARS_A,    0},
    // empty key and no value store: too long on the opening quote
    '{8'h00,        0, 0, ST_FOUND,    1, REG_KEY_LENGTH,     0},
    '{8'h00,        0, 0, ST_FOUND,    1, REG_VALUE_CAPACITY, 0},
    '{CHAR_EQUALS,  0, 0, ST_FOUND,    0, REG_KEY_CHARS_A,    0},
    '{CHAR_QUOTE,   1, 1, ST_LONG,     0, REG_KEY_CHARS_A,    0}
  };

  quoted_key_value_line_scanner u_dut (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text_byte     (text_byte),
    .end_of_buffer (end_of_buffer),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .is_status     (is_status),
    .value_char    (value_char),
    .status_code   (status_code),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  // closing status of a search; the buffer end returns to key matching
  function automatic bit close_search(input status_t code, input logic eob);
    step_result = '{is_status: 1'b1, value_char: 8'h00, status_code: code};
    scan_state  = eob ? SCAN_KEY : SCAN_DRAIN;
    key_pos     = 0;
    value_len   = 0;
    return 1'b1;
  endfunction

  // advance the shadow scanner by one byte; returns 1 when a result is due
  function automatic bit scan_step(input logic [7:0] b, input logic eob);
    int klen;
    klen = (key_len_q > MAX_KEY_LENGTH) ? MAX_KEY_LENGTH : int'(key_len_q);
    case (scan_state)
      SCAN_KEY: begin
        if (b == CHAR_NUL) return close_search(ST_NOTFOUND, eob);
        if (b == CHAR_NEWLINE) begin
          key_pos = 0;
        end else if (key_pos < klen) begin
          if (b == key_store[key_pos]) key_pos++;
          else scan_state = SCAN_SKIP;
        end else if (b == CHAR_EQUALS) begin
          scan_state = SCAN_QUOTE;
        end else begin
          scan_state = SCAN_SKIP;
        end
      end
      SCAN_QUOTE: begin
        if (b == CHAR_NUL) return close_search(ST_NOTFOUND, eob);
        if (b == CHAR_NEWLINE) begin
          scan_state = SCAN_KEY;
          key_pos    = 0;
        end else if (b == CHAR_QUOTE) begin
          if (cap_q == 8'd0) return close_search(ST_LONG, eob);
          scan_state = SCAN_VALUE;
          value_len  = 0;
          if (eob) return close_search(ST_UNTERM, eob);
        end else begin
          scan_state = SCAN_SKIP;
        end
      end
      SCAN_VALUE: begin
        if (b == CHAR_QUOTE) return close_search(ST_FOUND, eob);
        if (b == CHAR_NUL) return close_search(ST_UNTERM, eob);
        if (value_len + 1 >= int'(cap_q)) return close_search(ST_LONG, eob);
        if (eob) return close_search(ST_UNTERM, eob);
        value_len++;
        step_result = '{is_status: 1'b0, value_char: b, status_code: ST_FOUND};
        return 1'b1;
      end
      SCAN_SKIP: begin
        if (b == CHAR_NUL) return close_search(ST_NOTFOUND, eob);
        if (b == CHAR_NEWLINE) begin
          scan_state = SCAN_KEY;
          key_pos    = 0;
        end
      end
      default: begin
        if (eob) begin
          scan_state = SCAN_KEY;
          key_pos    = 0;
          value_len  = 0;
        end
        return 1'b0;
      end
    endcase
    if (eob) return close_search(ST_NOTFOUND, eob);
    return 1'b0;
  endfunction

  // one buffer of lines: mostly key lines with random values, some spoilt,
  // ordinary text and raw noise, sometimes cut short
  function automatic void build_buffer();
    int klen;
    int vmax;
    int start;
    int n;
    int cut;
    int i;
    int kind;
    buffer_bytes.delete();
    klen = (key_len_q > MAX_KEY_LENGTH) ? MAX_KEY_LENGTH : int'(key_len_q);
    vmax = (cap_q > 8'd24) ? 24 : int'(cap_q) + 1;
    repeat ($urandom_range(1, 4)) begin
      kind  = $urandom_range(99);
      start = buffer_bytes.size();
      if (kind < 55) begin
        for (i = 0; i < klen; i++) buffer_bytes.push_back(key_store[i]);
        buffer_bytes.push_back(CHAR_EQUALS);
        buffer_bytes.push_back(CHAR_QUOTE);
        repeat ($urandom_range(0, vmax)) begin
          if ($urandom_range(15) == 0) buffer_bytes.push_back(8'($urandom_range(255)));
          else buffer_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(9) != 0) buffer_bytes.push_back(CHAR_QUOTE);
        buffer_bytes.push_back(CHAR_NEWLINE);
        // broken key line: one byte replaced
        if (kind < 15) begin
          n = $urandom_range(start, buffer_bytes.size() - 1);
          buffer_bytes[n] = 8'($urandom_range(255));
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(0, 12)) buffer_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        buffer_bytes.push_back(CHAR_NEWLINE);
      end else begin
        repeat ($urandom_range(1, 6)) buffer_bytes.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) < 3) begin
      cut = $urandom_range(1, buffer_bytes.size());
      buffer_bytes = buffer_bytes[0:cut-1];
    end
  endfunction

  // present one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid    <= 1'b1;
    text_byte     <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
  endtask

  // register write: setup cycle, access cycle, then psel is dropped before the task returns
  task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [REG_DATA_W-1:0] value);
    int k;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_KEY_CHARS_A, REG_KEY_CHARS_B, REG_KEY_CHARS_C: begin
        for (k = 0; k < 8; k++) key_store[8 * int'(sel) + k] = value[8*k +: 8];
      end
      REG_KEY_LENGTH:     key_len_q = value[KEY_POS_W-1:0];
      REG_VALUE_CAPACITY: cap_q = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    text_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare every accepted result against the oldest expectation
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result at %0t: status=%0b char=%02h code=%0d",
                   $time, is_status, value_char, status_code);
      end else begin
        want = pending_results.pop_front();
        if (is_status !== want.is_status || value_char !== want.value_char ||
            status_code !== want.status_code) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"mismatch at %0t: expected status=%0b char=%02h code=%0d, ",
                      "got status=%0b char=%02h code=%0d"},
                     $time, want.is_status, want.value_char, want.status_code,
                     is_status, value_char, status_code);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (result_valid && result_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t                row;
    logic [REG_DATA_W-1:0]    word;
    logic [REG_SEL_W-1:0]     sel;
    bit                       hit;
    int                       phase_idx;
    int                       sent;
    int                       klen;
    int                       eff;
    int                       cap;
    int                       r;
    int                       c;
    int                       i;

    foreach (key_store[k]) key_store[k] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table, status codes pinned where obvious
    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.reg_sel, row.reg_value);
      end else begin
        send_byte(row.text, row.eob);
        hit = scan_step(row.text, row.eob);
        if (row.pinned)
          pending_results.push_back('{is_status: 1'b1, value_char: 8'h00,
                                      status_code: row.pin_code});
        else if (hit)
          pending_results.push_back(step_result);
      end
    end

    // random buffers over several register settings and idling modes
    for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
      case (phase_idx / 3)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase_idx)
        0: begin
          klen = MAX_KEY_LENGTH;
          cap  = 255;
        end
        1: begin
          klen = 31;
          cap  = 1;
        end
        2: begin
          klen = 0;
          cap  = 0;
        end
        default: begin
          klen = $urandom_range(1, 6);
          cap  = $urandom_range(2, 20);
        end
      endcase
      eff = (klen > MAX_KEY_LENGTH) ? MAX_KEY_LENGTH : klen;
      wait_idle();
      // printable key characters where in use, except for fully random keys
      for (r = 0; r < 3; r++) begin
        word = '0;
        for (c = 0; c < 8; c++) begin
          if (8*r + c < eff && phase_idx % 4 != 3)
            word[8*c +: 8] = 8'($urandom_range(8'h21, 8'h7E));
          else
            word[8*c +: 8] = 8'($urandom_range(255));
        end
        sel = (r == 0) ? REG_KEY_CHARS_A : (r == 1) ? REG_KEY_CHARS_B : REG_KEY_CHARS_C;
        write_reg(sel, word);
      end
      write_reg(REG_KEY_LENGTH, REG_DATA_W'(klen));
      write_reg(REG_VALUE_CAPACITY, REG_DATA_W'(cap));

      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_buffer();
        for (i = 0; i < buffer_bytes.size(); i++) begin
          send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
          if (scan_step(buffer_bytes[i], i == buffer_bytes.size() - 1))
            pending_results.push_back(step_result);
        end
        sent += buffer_bytes.size();
      end
    end

    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/qkvls_pkg.sv
hdl/qkvls_cfg.sv
hdl/quoted_key_value_line_scanner.sv
dv/tb.sv
